// ----- hdl/assert_macros.svh -----
// assertion macros shared by the moving average filter modules
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/maf_pkg.sv -----
// moving average filter package: operation codes and fixed field widths
// no dependencies
package maf_pkg;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    localparam int CFG_BITS  = 7;
    localparam int HELD_BITS = 7;

endpackage

// ----- hdl/moving_average_filter.sv -----
// moving average filter over a configurable window of signed fixed-point samples
// a sample transaction passes the front part, the two-entry queue and the bit-serial
// divider, over a dividend of WW = SAMPLE_BITS + clog2(WINDOW_MAX) bits (38 at defaults);
// the divider takes the next sample only once its last result is stored
// reset: asynchronous active low; window 8, filter empty, no ring clearing pass
// depends on maf_pkg, maf_front, maf_fifo, maf_back
module moving_average_filter
    import maf_pkg::*;
#(
    parameter int WINDOW_MAX  = 64,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_BITS-1:0]    cfg_wr_data,
    input  logic                   push,
    output logic                   full,
    input  logic                   op,
    input  logic [SAMPLE_BITS-1:0] sample,
    output logic                   empty,
    input  logic                   pop,
    output logic [SAMPLE_BITS-1:0] average,
    output logic [HELD_BITS-1:0]   samples_held
);

    localparam int PW = $clog2(WINDOW_MAX);
    localparam int CW = $clog2(WINDOW_MAX + 1);
    localparam int TW = SAMPLE_BITS + PW;

    logic          f_push, f_full, b_pop, b_empty;
    logic [TW-1:0] f_total, b_total;
    logic [CW-1:0] f_count, b_count;

    maf_front #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS),
        .PW          (PW),
        .CW          (CW),
        .TW          (TW)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .push        (push),
        .full        (full),
        .op          (op),
        .sample      (sample),
        .q_full      (f_full),
        .q_push      (f_push),
        .q_total     (f_total),
        .q_count     (f_count)
    );

    maf_fifo #(
        .DW (TW + CW)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (f_push),
        .wr_data ({f_total, f_count}),
        .full    (f_full),
        .rd_en   (b_pop),
        .rd_data ({b_total, b_count}),
        .empty   (b_empty)
    );

    maf_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .CW          (CW),
        .TW          (TW)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (b_empty),
        .q_pop        (b_pop),
        .q_total      (b_total),
        .q_count      (b_count),
        .empty        (empty),
        .pop          (pop),
        .average      (average),
        .samples_held (samples_held)
    );

endmodule

// ----- hdl/maf_fifo.sv -----
// two-entry queue between the front and back parts of the filter
// depends on assert_macros.svh
`include "assert_macros.svh"

module maf_fifo #(
    parameter int DW = 45
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  logic [DW-1:0] wr_data,
    output logic          full,
    input  logic          rd_en,
    output logic [DW-1:0] rd_data,
    output logic          empty
);

    logic [DW-1:0] mem [2];
    logic          wp_reg, wp_next;
    logic          rp_reg, rp_next;
    logic [1:0]    cnt_reg, cnt_next;
    logic          do_wr, do_rd;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign rd_data = mem[rp_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_comb
    begin
        wp_next  = do_wr ? ~wp_reg : wp_reg;
        rp_next  = do_rd ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg;
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    `ASSERT_ALWAYS(a_no_overflow, !(wr_en && full), "queue written while full")
    `ASSERT_ALWAYS(a_ptr_count, (cnt_reg != 2'd3) && ((cnt_reg == 2'd1) == (wp_reg != rp_reg)), "queue pointers disagree with count")

endmodule

// ----- hdl/maf_front.sv -----
// front part: takes transactions and config writes, keeps the sample ring,
// pointer, fill count and running total; depends on maf_pkg, assert_macros.svh
`include "assert_macros.svh"

module maf_front
    import maf_pkg::*;
#(
    parameter int WINDOW_MAX  = 64,
    parameter int SAMPLE_BITS = 32,
    parameter int PW          = $clog2(WINDOW_MAX),
    parameter int CW          = $clog2(WINDOW_MAX + 1),
    parameter int TW          = SAMPLE_BITS + PW
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_BITS-1:0]    cfg_wr_data,
    input  logic                   push,
    output logic                   full,
    input  logic                   op,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic                   q_full,
    output logic                   q_push,
    output logic [TW-1:0]          q_total,
    output logic [CW-1:0]          q_count
);

    localparam int WIN_RST = (8 > WINDOW_MAX) ? WINDOW_MAX : 8;

    logic [SAMPLE_BITS-1:0] ring [WINDOW_MAX];
    logic [SAMPLE_BITS-1:0] rd_q;
    logic [SAMPLE_BITS-1:0] smp_reg;
    logic [CW-1:0]          win_reg, win_next;
    logic [PW-1:0]          wp_reg, wp_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [TW-1:0]          total_reg, total_next;
    logic                   busy_reg, busy_next;
    logic                   accept, take_sample;
    logic                   evict;
    logic [TW-1:0]          old_ext, new_ext;
    logic [CW-1:0]          wp_inc;

    assign full        = busy_reg || q_full;
    assign accept      = push && !full;
    assign take_sample = accept && (op == OP_SAMPLE);

    assign evict   = (count_reg >= win_reg);
    assign old_ext = evict ? {{PW{rd_q[SAMPLE_BITS-1]}}, rd_q} : '0;
    assign new_ext = {{PW{smp_reg[SAMPLE_BITS-1]}}, smp_reg};
    assign wp_inc  = CW'(wp_reg) + CW'(1);

    assign q_push  = busy_reg;
    assign q_total = total_next;
    assign q_count = count_next;

    always_comb
    begin
        win_next   = win_reg;
        wp_next    = wp_reg;
        count_next = count_reg;
        total_next = total_reg;
        busy_next  = 1'b0;
        if (cfg_wr_en)
        begin
            if (cfg_wr_data == '0)
            begin
                win_next = CW'(1);
            end
            else if (32'(cfg_wr_data) > 32'(WINDOW_MAX))
            begin
                win_next = CW'(WINDOW_MAX);
            end
            else
            begin
                win_next = CW'(cfg_wr_data);
            end
            wp_next    = '0;
            count_next = '0;
            total_next = '0;
        end
        else if (busy_reg)
        begin
            total_next = total_reg - old_ext + new_ext;
            count_next = evict ? count_reg : count_reg + CW'(1);
            wp_next    = (wp_inc >= win_reg) ? '0 : PW'(wp_inc);
        end
        else if (accept)
        begin
            if (op == OP_CLEAR)
            begin
                wp_next    = '0;
                count_next = '0;
                total_next = '0;
            end
            else
            begin
                busy_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_sample)
        begin
            rd_q    <= ring[wp_reg];
            smp_reg <= sample;
        end
        if (busy_reg)
        begin
            ring[wp_reg] <= smp_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg   <= CW'(WIN_RST);
            wp_reg    <= '0;
            count_reg <= '0;
            total_reg <= '0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            win_reg   <= win_next;
            wp_reg    <= wp_next;
            count_reg <= count_next;
            total_reg <= total_next;
            busy_reg  <= busy_next;
        end
    end

    `ASSERT_ALWAYS(a_count_in_window, count_reg <= win_reg, "fill count above window")
    `ASSERT_ALWAYS(a_ptr_in_window, CW'(wp_reg) < win_reg, "write pointer outside window")
    `ASSERT_NEXT(a_push_count, busy_reg, count_reg != '0, "pushed with empty window")

endmodule

// ----- hdl/maf_back.sv -----
// back part: signed division of the running total by the sample count,
// one quotient bit per cycle, with a result register; depends on maf_pkg
module maf_back
    import maf_pkg::*;
#(
    parameter int SAMPLE_BITS = 32,
    parameter int CW          = 7,
    parameter int TW          = 38
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_empty,
    output logic                   q_pop,
    input  logic [TW-1:0]          q_total,
    input  logic [CW-1:0]          q_count,
    output logic                   empty,
    input  logic                   pop,
    output logic [SAMPLE_BITS-1:0] average,
    output logic [HELD_BITS-1:0]   samples_held
);

    localparam int SW = $clog2(TW + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]             state_reg, state_next;
    logic                   neg_reg, neg_next;
    logic [TW-1:0]          dvd_reg, dvd_next;
    logic [CW-1:0]          rem_reg, rem_next;
    logic [CW-1:0]          div_reg, div_next;
    logic [SW-1:0]          step_reg, step_next;
    logic                   oval_reg, oval_next;
    logic [SAMPLE_BITS-1:0] avg_reg, avg_next;
    logic [HELD_BITS-1:0]   held_reg, held_next;
    logic [CW:0]            shifted, diff;
    logic                   qbit;
    logic [TW-1:0]          quot;

    assign shifted = {rem_reg, dvd_reg[TW-1]};
    assign diff    = shifted - {1'b0, div_reg};
    assign qbit    = (shifted >= {1'b0, div_reg});
    assign quot    = neg_reg ? (~dvd_reg + TW'(1)) : dvd_reg;

    assign q_pop        = (state_reg == ST_IDLE) && !q_empty;
    assign empty        = !oval_reg;
    assign average      = avg_reg;
    assign samples_held = held_reg;

    always_comb
    begin
        state_next = state_reg;
        neg_next   = neg_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        step_next  = step_reg;
        avg_next   = avg_reg;
        held_next  = held_reg;
        oval_next  = (pop && oval_reg) ? 1'b0 : oval_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    neg_next   = q_total[TW-1];
                    dvd_next   = q_total[TW-1] ? (~q_total + TW'(1)) : q_total;
                    rem_next   = '0;
                    div_next   = q_count;
                    step_next  = SW'(TW);
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                rem_next  = qbit ? diff[CW-1:0] : shifted[CW-1:0];
                dvd_next  = {dvd_reg[TW-2:0], qbit};
                step_next = step_reg - SW'(1);
                if (step_reg == SW'(1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!oval_reg || pop)
                begin
                    avg_next   = quot[SAMPLE_BITS-1:0];
                    held_next  = HELD_BITS'(div_reg);
                    oval_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
        avg_reg  <= avg_next;
        held_reg <= held_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            oval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            oval_reg  <= oval_next;
        end
    end

endmodule

// ----- dv/moving_average_filter_tb.sv -----
// self-checking testbench for moving_average_filter: random and directed sample/clear traffic
// with window changes, checked against a running-sum predictor in a small scoreboard class
// depends on maf_pkg and the moving_average_filter rtl
`timescale 1ns / 100ps

module moving_average_filter_tb
    import maf_pkg::*;
();

    localparam int WIN_MAX      = 64;
    localparam int SMP_BITS     = 32;
    localparam int DRAIN_CYCLES = 60;
    localparam int STALL_LIMIT  = 20000;
    localparam int HOLD_CYCLES  = 2000;
    localparam int HOLD_AT      = 400;
    localparam int PHASE_ITEMS  = 175;
    localparam int NUM_PHASES   = 10;

    class avg_scoreboard;
        int unsigned win_len;
        logic signed [SMP_BITS-1:0] ring [WIN_MAX];
        int unsigned wr_ptr;
        int unsigned fill;
        longint total;
        logic [SMP_BITS-1:0] avg_q [$];
        logic [HELD_BITS-1:0] held_q [$];
        int errors;
        int checked;

        function new();
            win_len = 8;
            errors = 0;
            checked = 0;
            clear_state();
        endfunction

        function void clear_state();
            wr_ptr = 0;
            fill = 0;
            total = 0;
        endfunction

        function void set_window(logic [CFG_BITS-1:0] v);
            int unsigned w;
            w = v;
            if (w < 1)
                w = 1;
            if (w > WIN_MAX)
                w = WIN_MAX;
            win_len = w;
            clear_state();
        endfunction

        function void note_input(logic op_v, logic [SMP_BITS-1:0] smp);
            int unsigned slot;
            longint q;
            if (op_v == OP_CLEAR)
            begin
                clear_state();
                return;
            end
            slot = wr_ptr % WIN_MAX;
            if (fill >= win_len)
                total -= ring[slot];
            ring[slot] = smp;
            total += ring[slot];
            wr_ptr = slot + 1;
            if (wr_ptr >= win_len)
                wr_ptr = 0;
            if (fill < win_len)
                fill++;
            // signed division truncates toward zero
            q = total / longint'(fill);
            avg_q.push_back(SMP_BITS'(q));
            held_q.push_back(HELD_BITS'(fill));
        endfunction

        function void check_result(logic [SMP_BITS-1:0] avg, logic [HELD_BITS-1:0] held);
            logic [SMP_BITS-1:0] exp_avg;
            logic [HELD_BITS-1:0] exp_held;
            if (avg_q.size() == 0)
            begin
                $display("%0t: unexpected result average %h samples_held %0d", $time, avg, held);
                errors++;
                return;
            end
            exp_avg = avg_q.pop_front();
            exp_held = held_q.pop_front();
            checked++;
            if (avg !== exp_avg)
            begin
                $display("%0t: average expected %h actual %h", $time, exp_avg, avg);
                errors++;
            end
            if (held !== exp_held)
            begin
                $display("%0t: samples_held expected %0d actual %0d", $time, exp_held, held);
                errors++;
            end
        endfunction
    endclass

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic [CFG_BITS-1:0]     cfg_wr_data = '0;
    logic                    push = 1'b0;
    logic                    full;
    logic                    op = OP_SAMPLE;
    logic [SMP_BITS-1:0]     sample = '0;
    logic                    empty;
    logic                    pop = 1'b0;
    logic [SMP_BITS-1:0]     average;
    logic [HELD_BITS-1:0]    samples_held;

    avg_scoreboard sb = new();
    bit gaps_on = 1'b1;
    int n_sent = 0;
    int n_clears = 0;
    int n_cfg = 0;
    int stall_cycles = 0;

    moving_average_filter #(
        .WINDOW_MAX  (WIN_MAX),
        .SAMPLE_BITS (SMP_BITS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .push         (push),
        .full         (full),
        .op           (op),
        .sample       (sample),
        .empty        (empty),
        .pop          (pop),
        .average      (average),
        .samples_held (samples_held)
    );

    always #5 clk = ~clk;

    task automatic send_item(input logic op_v, input logic [SMP_BITS-1:0] smp);
        while (gaps_on && $urandom_range(99) < 23)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        op <= op_v;
        sample <= smp;
        do
            @(negedge clk);
        while (full);
        @(posedge clk);
        sb.note_input(op_v, smp);
        n_sent++;
        if (op_v == OP_CLEAR)
            n_clears++;
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (sb.avg_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_window(input logic [CFG_BITS-1:0] v);
        wait_drained();
        // clear transactions leave no result, so give the pipeline time to settle
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_window(v);
        n_cfg++;
    endtask

    function automatic logic [SMP_BITS-1:0] rand_sample();
        case ($urandom_range(9))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return SMP_BITS'(int'($urandom_range(200)) - 100);
            3: return 32'h7fff_ffff - $urandom_range(15);
            4: return 32'h8000_0000 + $urandom_range(15);
            default: return $urandom;
        endcase
    endfunction

    // result side: random pop gaps plus one long hold-off
    initial
    begin
        logic [SMP_BITS-1:0] got_avg;
        logic [HELD_BITS-1:0] got_held;
        bit take;
        bit held_once;
        int hold_left;
        held_once = 1'b0;
        hold_left = 0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            @(negedge clk);
            take = pop && !empty;
            got_avg = average;
            got_held = samples_held;
            @(posedge clk);
            if (take)
                sb.check_result(got_avg, got_held);
            if (!held_once && sb.checked >= HOLD_AT)
            begin
                held_once = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
                pop <= !(gaps_on && $urandom_range(99) < 23);
        end
    end

    // watchdog on cycles without any accepted transaction
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("FAIL moving_average_filter");
                $finish;
            end
        end
    end

    initial
    begin
        logic [CFG_BITS-1:0] phase_win [NUM_PHASES];
        logic [CFG_BITS-1:0] w;
        phase_win = '{7'd1, 7'd64, 7'd127, 7'd2, 7'd65, 7'd3, 7'd0, 7'd0, 7'd0, 7'd8};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes at the reset window, overflow of the window, clear
        send_item(OP_SAMPLE, 32'h7fff_ffff);
        send_item(OP_SAMPLE, 32'h7fff_ffff);
        send_item(OP_SAMPLE, 32'h8000_0000);
        send_item(OP_SAMPLE, 32'hffff_ffff);
        send_item(OP_SAMPLE, 32'h0000_0001);
        send_item(OP_SAMPLE, 32'h0000_0000);
        send_item(OP_SAMPLE, 32'h8000_0000);
        send_item(OP_SAMPLE, 32'h8000_0000);
        send_item(OP_SAMPLE, 32'h8000_0000);
        send_item(OP_SAMPLE, 32'h8000_0000);
        send_item(OP_CLEAR, 32'hffff_ffff);
        send_item(OP_SAMPLE, 32'hffff_fffd);
        // negative mean that truncates toward zero
        send_item(OP_SAMPLE, 32'h0000_0002);
        send_item(OP_SAMPLE, 32'hffff_fffe);
        send_item(OP_CLEAR, 32'h0000_0000);
        send_item(OP_SAMPLE, 32'h0000_0005);
        // window of zero is taken as one
        write_window(7'd0);
        send_item(OP_SAMPLE, 32'h8000_0000);
        send_item(OP_SAMPLE, 32'h7fff_ffff);
        send_item(OP_SAMPLE, 32'hffff_ffff);
        // window above the maximum is taken as the maximum
        write_window(7'd127);
        send_item(OP_SAMPLE, 32'h7fff_ffff);
        send_item(OP_SAMPLE, 32'h8000_0000);
        send_item(OP_CLEAR, 32'h1234_5678);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            w = (p >= 6 && p <= 8) ? CFG_BITS'($urandom_range(127)) : phase_win[p];
            write_window(w);
            gaps_on = (p != 4);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (p == 6 && i == PHASE_ITEMS / 2)
                    wait_drained();
                if ($urandom_range(99) < 4)
                    send_item(OP_CLEAR, $urandom);
                else
                    send_item(OP_SAMPLE, rand_sample());
            end
        end
        gaps_on = 1'b1;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.avg_q.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, sb.avg_q.size());
            sb.errors++;
        end
        $display("sent %0d transactions (%0d clears) over %0d window settings",
                 n_sent, n_clears, n_cfg + 1);
        $display("checked %0d results, %0d mismatches", sb.checked, sb.errors);
        if (sb.errors == 0)
            $display("PASS moving_average_filter");
        else
            $display("FAIL moving_average_filter");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/maf_pkg.sv
hdl/maf_fifo.sv
hdl/maf_front.sv
hdl/maf_back.sv
hdl/moving_average_filter.sv
dv/moving_average_filter_tb.sv
